// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and controller/datapath types for the bitmap block
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int WORD_BITS_DEF  = 32;

    // Fixed field widths
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 11;
    localparam int BS_W   = 17;
    localparam int CFG_W  = 64;
    localparam int PADDR_W = 5;

    // Configuration register indexes
    localparam logic [1:0] REG_TOTAL_BLOCKS = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_A_RD,
        OP_A_BIT,
        OP_A_MUL,
        OP_A_ADD,
        OP_M_RD,
        OP_M_LD,
        OP_M_BIT,
        OP_M_WR,
        OP_F0,
        OP_F1,
        OP_F2,
        OP_DIV,
        OP_F_MARK,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ok;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic alloc_bad;
        logic i_end;
        logic hit;
        logic b_last;
        logic flush;
        logic k_zero;
        logic fail1;
        logic end_gt;
        logic div_last;
        logic cnt_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: design/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// Request and response channels of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] address;

    modport source (output valid, kind, count, address, input ready);
    modport sink   (input valid, kind, count, address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  free_count;

    modport source (output valid, ok, block_address, free_count, input ready);
    modport sink   (input valid, ok, block_address, free_count, output ready);
endinterface

`default_nettype wire

// File: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: map clear, first-fit scan, run marking and free range checks.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl import bba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  clear_start,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_A_RD  = 16'h0004,
        S_A_BIT = 16'h0008,
        S_A_MUL = 16'h0010,
        S_A_ADD = 16'h0020,
        S_M_RD  = 16'h0040,
        S_M_LD  = 16'h0080,
        S_M_BIT = 16'h0100,
        S_M_WR  = 16'h0200,
        S_F0    = 16'h0400,
        S_F1    = 16'h0800,
        S_F2    = 16'h1000,
        S_DIV1  = 16'h2000,
        S_FMARK = 16'h4000,
        S_DONE  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        case (state_reg)
            S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.is_free)
                        state_next = S_F0;
                    else if (stat.alloc_bad)
                    begin
                        state_next = S_DONE;
                        ok_next    = 1'b0;
                    end
                    else
                        state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                if (stat.i_end)
                begin
                    state_next = S_DONE;
                    ok_next    = 1'b0;
                end
                else
                    state_next = S_A_BIT;
            end
            S_A_BIT:
            begin
                if (stat.i_end)
                begin
                    state_next = S_DONE;
                    ok_next    = 1'b0;
                end
                else if (stat.hit)
                    state_next = S_A_MUL;
                else if (stat.b_last)
                    state_next = S_A_RD;
            end
            S_A_MUL: state_next = S_A_ADD;
            S_A_ADD:
            begin
                state_next = S_M_RD;
                ok_next    = 1'b1;
            end
            S_M_RD: state_next = S_M_LD;
            S_M_LD: state_next = S_M_BIT;
            S_M_BIT: if (stat.flush) state_next = S_M_WR;
            S_M_WR: state_next = stat.k_zero ? S_DONE : S_M_RD;
            S_F0: state_next = S_F1;
            S_F1:
            begin
                if (stat.fail1)
                begin
                    state_next = S_DONE;
                    ok_next    = 1'b0;
                end
                else
                    state_next = S_F2;
            end
            S_F2:
            begin
                if (stat.end_gt)
                begin
                    state_next = S_DONE;
                    ok_next    = 1'b0;
                end
                else
                    state_next = S_DIV1;
            end
            S_DIV1: if (stat.div_last) state_next = S_FMARK;
            S_FMARK:
            begin
                ok_next    = 1'b1;
                state_next = stat.cnt_zero ? S_DONE : S_M_RD;
            end
            S_DONE: if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
        if (clear_start)
            state_next = S_CLEAR;
    end

    // Command decode
    always_comb
    begin
        cmd.ok = ok_reg;
        case (state_reg)
            S_CLEAR: cmd.op = OP_CLEAR;
            S_IDLE:  cmd.op = in_valid ? OP_ACCEPT : OP_NONE;
            S_A_RD:  cmd.op = OP_A_RD;
            S_A_BIT: cmd.op = OP_A_BIT;
            S_A_MUL: cmd.op = OP_A_MUL;
            S_A_ADD: cmd.op = OP_A_ADD;
            S_M_RD:  cmd.op = OP_M_RD;
            S_M_LD:  cmd.op = OP_M_LD;
            S_M_BIT: cmd.op = OP_M_BIT;
            S_M_WR:  cmd.op = OP_M_WR;
            S_F0:    cmd.op = OP_F0;
            S_F1:    cmd.op = OP_F1;
            S_F2:    cmd.op = OP_F2;
            S_DIV1:  cmd.op = OP_DIV;
            S_FMARK: cmd.op = OP_F_MARK;
            S_DONE:  cmd.op = OP_DONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule

`default_nettype wire

// File: design/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: used-bit map memory, scan and mark counters, shared multiplier,
// restoring divider, configuration registers and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    // request payload
    input  wire logic              in_kind,
    input  wire logic [CNT_W-1:0]  in_count,
    input  wire logic [ADDR_W-1:0] in_address,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_idx,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    output logic [CFG_W-1:0]       cfg_rdata,
    // response
    bba_rsp_if.source              rsp
);

    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = (IW > CNT_W) ? IW : CNT_W;
    localparam int MW = PW + BS_W;
    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LW = $clog2(WORD_BITS);
    localparam int RW = ADDR_W + 1;
    localparam int SW = $clog2(IW);
    localparam int RST_POOL = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;

    // Configuration registers
    logic [CNT_W-1:0]  total_reg;
    logic [BS_W-1:0]   bsize_reg;
    logic [ADDR_W-1:0] base_reg;

    // Map memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        clr_ptr_reg;

    // Request and scan state
    logic              kind_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [IW-1:0]     i_reg;
    logic [AW-1:0]     w_reg;
    logic [LW-1:0]     b_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [IW-1:0]     start_reg;
    logic [AW-1:0]     sw_reg;
    logic [LW-1:0]     sb_reg;

    // Mark state
    logic [WORD_BITS-1:0] wbuf_reg;
    logic [AW-1:0]        mw_reg;
    logic [LW-1:0]        mb_reg;
    logic [CNT_W-1:0]     k_reg;
    logic                 mval_reg;

    // Arithmetic
    logic [MW-1:0]     mul_reg;
    logic [RW-1:0]     off_reg;
    logic [RW-1:0]     end_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     dsh_reg;
    logic [IW-1:0]     q_reg;
    logic [SW-1:0]     step_reg;

    // Free counter and response
    logic [CNT_W-1:0]  free_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [CNT_W-1:0]  out_free_reg;

    logic [PW-1:0]     pool_pw;
    logic [CNT_W-1:0]  pool;
    logic [PW-1:0]     wr_total_pw;
    logic [CNT_W-1:0]  wr_pool;
    logic [PW-1:0]     mul_a;
    logic              out_free;
    logic [CNT_W:0]    free_sum;
    logic [CNT_W-1:0]  free_upd;
    logic              div_ge;

    // Pool size
    assign pool_pw = (PW'(total_reg) > PW'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : PW'(total_reg);
    assign pool    = pool_pw[CNT_W-1:0];
    assign wr_total_pw = PW'(cfg_wdata[CNT_W-1:0]);
    assign wr_pool = (wr_total_pw > PW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                     : cfg_wdata[CNT_W-1:0];

    // Shared multiplier operand
    always_comb
    begin
        case (cmd.op)
            OP_A_MUL: mul_a = PW'(start_reg);
            OP_F0:    mul_a = PW'(count_reg);
            default:  mul_a = pool_pw;
        endcase
    end

    assign div_ge   = (rem_reg >= dsh_reg);
    assign out_free = !out_valid_reg || rsp.ready;

    // Free counter after a successful operation
    assign free_sum = {1'b0, free_reg} + {1'b0, count_reg};
    always_comb
    begin
        if (kind_reg == KIND_ALLOC)
            free_upd = free_reg - count_reg;
        else if (free_sum > {1'b0, pool})
            free_upd = pool;
        else
            free_upd = free_sum[CNT_W-1:0];
    end

    // Status
    always_comb
    begin
        stat.clr_last  = (clr_ptr_reg == AW'(MAP_WORDS - 1));
        stat.is_free   = (in_kind == KIND_FREE);
        stat.alloc_bad = (in_count == '0) || (in_count > free_reg);
        stat.i_end     = (PW'(i_reg) == pool_pw);
        stat.hit       = !rd_data_reg[b_reg] &&
                         ({1'b0, run_reg} + 1'b1 == {1'b0, count_reg});
        stat.b_last    = (b_reg == LW'(WORD_BITS - 1));
        stat.flush     = (k_reg == CNT_W'(1)) || (mb_reg == LW'(WORD_BITS - 1));
        stat.k_zero    = (k_reg == '0);
        stat.fail1     = (bsize_reg == '0) || off_reg[RW-1];
        stat.end_gt    = (end_reg > RW'(mul_reg));
        stat.div_last  = (step_reg == '0);
        stat.cnt_zero  = (count_reg == '0);
        stat.out_free  = out_free;
    end

    // Map memory: single write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLEAR)
            map_mem[clr_ptr_reg] <= '0;
        else if (cmd.op == OP_M_WR)
            map_mem[mw_reg] <= wbuf_reg;
        if (cmd.op == OP_A_RD)
            rd_data_reg <= map_mem[w_reg];
        else if (cmd.op == OP_M_RD)
            rd_data_reg <= map_mem[mw_reg];
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                kind_reg  <= in_kind;
                count_reg <= in_count;
                addr_reg  <= in_address;
                i_reg     <= '0;
                w_reg     <= '0;
                b_reg     <= '0;
                run_reg   <= '0;
            end
            OP_A_BIT:
            begin
                if (rd_data_reg[b_reg])
                    run_reg <= '0;
                else
                begin
                    if (run_reg == '0)
                    begin
                        start_reg <= i_reg;
                        sw_reg    <= w_reg;
                        sb_reg    <= b_reg;
                    end
                    run_reg <= run_reg + 1'b1;
                end
                i_reg <= i_reg + 1'b1;
                if (b_reg == LW'(WORD_BITS - 1))
                begin
                    b_reg <= '0;
                    w_reg <= w_reg + 1'b1;
                end
                else
                    b_reg <= b_reg + 1'b1;
            end
            OP_A_MUL: mul_reg <= mul_a * MW'(bsize_reg);
            OP_A_ADD:
            begin
                res_addr_reg <= base_reg + ADDR_W'(mul_reg);
                mw_reg   <= sw_reg;
                mb_reg   <= sb_reg;
                k_reg    <= count_reg;
                mval_reg <= 1'b1;
            end
            OP_M_LD: wbuf_reg <= rd_data_reg;
            OP_M_BIT:
            begin
                wbuf_reg[mb_reg] <= mval_reg;
                k_reg <= k_reg - 1'b1;
                mb_reg <= (mb_reg == LW'(WORD_BITS - 1)) ? '0 : mb_reg + 1'b1;
            end
            OP_M_WR: mw_reg <= mw_reg + 1'b1;
            OP_F0:
            begin
                off_reg <= {1'b0, addr_reg} - {1'b0, base_reg};
                mul_reg <= mul_a * MW'(bsize_reg);
            end
            OP_F1:
            begin
                end_reg <= off_reg + RW'(mul_reg);
                mul_reg <= mul_a * MW'(bsize_reg);
            end
            OP_F2:
            begin
                rem_reg  <= off_reg;
                dsh_reg  <= RW'(bsize_reg) << (IW - 1);
                step_reg <= SW'(IW - 1);
            end
            OP_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg    <= {q_reg[IW-2:0], div_ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 1'b1;
            end
            OP_F_MARK:
            begin
                // first block index split into map word and bit
                mw_reg   <= AW'(q_reg / WORD_BITS);
                mb_reg   <= LW'(q_reg % WORD_BITS);
                k_reg    <= count_reg;
                mval_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    // Configuration, free counter, clear pointer, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= CNT_W'(1024);
            bsize_reg     <= BS_W'(64);
            base_reg      <= '0;
            free_reg      <= CNT_W'(RST_POOL);
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            if (cmd.op == OP_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.ok)
                    free_reg <= free_upd;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_TOTAL_BLOCKS:
                    begin
                        total_reg   <= cfg_wdata[CNT_W-1:0];
                        free_reg    <= wr_pool;
                        clr_ptr_reg <= '0;
                    end
                    REG_BLOCK_SIZE:   bsize_reg <= cfg_wdata[BS_W-1:0];
                    REG_BASE_ADDRESS: base_reg  <= cfg_wdata[ADDR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DONE && out_free)
        begin
            out_ok_reg   <= cmd.ok;
            out_addr_reg <= (cmd.ok && kind_reg == KIND_ALLOC) ? res_addr_reg : '0;
            out_free_reg <= cmd.ok ? free_upd : free_reg;
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_idx)
            REG_TOTAL_BLOCKS: cfg_rdata = CFG_W'(total_reg);
            REG_BLOCK_SIZE:   cfg_rdata = CFG_W'(bsize_reg);
            REG_BASE_ADDRESS: cfg_rdata = CFG_W'(base_reg);
            default:          cfg_rdata = '0;
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = out_ok_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.free_count    = out_free_reg;

endmodule

`default_nettype wire

// File: design/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit contiguous block allocator over a used-bit map.
//
// Channels: req carries kind (allocate/free), count and address; rsp returns
// ok, block_address and free_count, one response per request, in order.
// Registers on the APB port: total_blocks at 0x0, block size at 0x8,
// base_address at 0x10 (64-bit data). Writing total_blocks clears the map.
// One request is worked at a time; req.ready is high only when idle.
// Allocate: accept, then one map read per word scanned and a bit test per
// bit scanned (the whole pool when no run fits), a multiply and an add to
// form the address, and per map word a read, a load, one update per bit and
// a write-back to mark the run (one bit per cycle on the single map port),
// then the response. Free: accept, range check, the bit-serial divide by
// the block size and the response, plus the same marking when the range
// is accepted.
// Reset and a total_blocks write start a clearing pass over every map word
// (one map word per cycle) with req.ready low.
// A finished response sits in an output register; while rsp stalls the
// block waits at completion of the next request until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    bba_req_if.sink                 req,
    bba_rsp_if.source               rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]        prdata,
    output logic                    pready
);

    cmd_t       cmd;
    stat_t      stat;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic       clear_start;

    // APB decode
    assign pready      = 1'b1;
    assign cfg_idx     = paddr[4:3];
    assign cfg_we      = psel && penable && pwrite && pready;
    assign clear_start = cfg_we && (cfg_idx == REG_TOTAL_BLOCKS);

    bba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .clear_start (clear_start),
        .stat        (stat),
        .cmd         (cmd)
    );

    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (req.kind),
        .in_count   (req.count),
        .in_address (req.address),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (pwdata),
        .cfg_rdata  (prdata),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
